// ----- rtl/core/mqc_pkg.sv -----
// ----------------------------------------------------------------------------
// mqc_pkg
// Shared types and constants of the MLD query classifier.
// ----------------------------------------------------------------------------
package mqc_pkg;

  localparam int unsigned OFFSET_BITS = 16;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
  localparam logic [OFFSET_BITS-1:0] FIXED_HDR_BYTES = OFFSET_BITS'(40);
  localparam int unsigned EXT_UNIT_SHIFT = 3;

  localparam logic [7:0] NH_HOP_BY_HOP   = 8'd0;
  localparam logic [7:0] NH_ROUTING      = 8'd43;
  localparam logic [7:0] NH_FRAGMENT     = 8'd44;
  localparam logic [7:0] NH_DEST_OPTIONS = 8'd60;
  localparam logic [7:0] NH_ICMPV6       = 8'd58;

  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 64;

  localparam logic [63:0] DEST_HIGH_RST  = 64'hff02_0000_0000_0000;
  localparam logic [63:0] DEST_LOW_RST   = 64'h0000_0000_0000_0001;
  localparam logic [15:0] V1_SIZE_RST    = 16'd24;
  localparam logic [15:0] V2_MIN_RST     = 16'd28;
  localparam logic [7:0]  QUERY_TYPE_RST = 8'd130;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DEST_ADDR_HIGH    = 3'd0,
    CFG_DEST_ADDR_LOW     = 3'd1,
    CFG_V1_QUERY_SIZE     = 3'd2,
    CFG_V2_MIN_QUERY_SIZE = 3'd3,
    CFG_QUERY_TYPE_CODE   = 3'd4,
    CFG_FAMILY_IS_IPV6    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_MLDV1 = 2'd1,
    VERDICT_MLDV2 = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] query_length;
  } out_item_t;

  typedef struct packed {
    logic [63:0] dest_addr_high;
    logic [63:0] dest_addr_low;
    logic [15:0] v1_query_size;
    logic [15:0] v2_min_query_size;
    logic [7:0]  query_type_code;
    logic        family_is_ipv6;
  } cfg_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } byte_beat_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_beat_t;

endpackage

// ----- rtl/core/mqc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// mqc_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module mqc_cfg_regs import mqc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEST_ADDR_HIGH:    cfg_d.dest_addr_high    = cfg_wdata_i;
        CFG_DEST_ADDR_LOW:     cfg_d.dest_addr_low     = cfg_wdata_i;
        CFG_V1_QUERY_SIZE:     cfg_d.v1_query_size     = cfg_wdata_i[15:0];
        CFG_V2_MIN_QUERY_SIZE: cfg_d.v2_min_query_size = cfg_wdata_i[15:0];
        CFG_QUERY_TYPE_CODE:   cfg_d.query_type_code   = cfg_wdata_i[7:0];
        CFG_FAMILY_IS_IPV6:    cfg_d.family_is_ipv6    = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_addr_high    <= DEST_HIGH_RST;
      cfg_q.dest_addr_low     <= DEST_LOW_RST;
      cfg_q.v1_query_size     <= V1_SIZE_RST;
      cfg_q.v2_min_query_size <= V2_MIN_RST;
      cfg_q.query_type_code   <= QUERY_TYPE_RST;
      cfg_q.family_is_ipv6    <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/mqc_input_stage.sv -----
// ----------------------------------------------------------------------------
// mqc_input_stage
// Input register for one packet byte beat.
// ----------------------------------------------------------------------------
module mqc_input_stage import mqc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_data_i,
  output byte_beat_t beat_o,
  input  logic       take_i
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
    end
  end

  assign beat_o.valid = valid_q;
  assign beat_o.item  = item_q;

endmodule

// ----- rtl/core/mqc_parser.sv -----
// ----------------------------------------------------------------------------
// mqc_parser
// Per-byte header walk: payload length, address compare, extension chain
// and query classification, with the verdict issued on the last byte.
// ----------------------------------------------------------------------------
module mqc_parser import mqc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  byte_beat_t   beat_i,
  output logic         take_o,
  input  logic         out_free_i,
  output result_beat_t result_o
);

  typedef struct packed {
    logic [OFFSET_BITS-1:0] byte_offset;
    logic [15:0]            payload_length;
    logic [7:0]             pending_next_header;
    logic [OFFSET_BITS-1:0] header_start;
    logic                   address_matches;
    logic                   walk_done;
    verdict_e               held_verdict;
    logic [15:0]            held_length;
    logic                   length_byte_next;
  } walk_state_t;

  localparam walk_state_t START_STATE = '{
    byte_offset:         '0,
    payload_length:      '0,
    pending_next_header: '0,
    header_start:        FIXED_HDR_BYTES,
    address_matches:     1'b1,
    walk_done:           1'b0,
    held_verdict:        VERDICT_NONE,
    held_length:         '0,
    length_byte_next:    1'b0
  };

  walk_state_t            st_q, st_d, cur, nx;
  logic [15:0][7:0]       addr_bytes;
  logic [3:0]             addr_idx;
  logic [7:0]             b;
  logic [OFFSET_BITS:0]   next_start;
  logic [16:0]            ext_bytes;
  logic [16:0]            query_diff;
  logic                   is_ext;
  logic                   fire;
  out_item_t              res;

  assign b          = beat_i.item.packet_byte;
  assign take_o     = beat_i.valid && (!beat_i.item.last_byte || out_free_i);
  assign fire       = take_o;
  assign addr_bytes = {cfg_i.dest_addr_high, cfg_i.dest_addr_low};

  always_comb begin
    cur        = beat_i.item.first_byte ? START_STATE : st_q;
    nx         = cur;
    addr_idx   = 4'(cur.byte_offset - OFFSET_BITS'(24));
    next_start = (OFFSET_BITS+1)'(cur.header_start) +
                 (((OFFSET_BITS+1)'(b) + (OFFSET_BITS+1)'(1)) << EXT_UNIT_SHIFT);
    ext_bytes  = '0;
    query_diff = '0;
    is_ext     = 1'b0;

    if (cur.byte_offset == OFFSET_BITS'(4)) begin
      nx.payload_length[15:8] = b;
    end else if (cur.byte_offset == OFFSET_BITS'(5)) begin
      nx.payload_length[7:0] = b;
    end else if (cur.byte_offset == OFFSET_BITS'(6)) begin
      nx.pending_next_header = b;
    end else if (cur.byte_offset >= OFFSET_BITS'(24) &&
                 cur.byte_offset < OFFSET_BITS'(40)) begin
      if (b != addr_bytes[4'd15 - addr_idx]) begin
        nx.address_matches = 1'b0;
      end
    end

    is_ext = nx.pending_next_header == NH_HOP_BY_HOP   ||
             nx.pending_next_header == NH_ROUTING      ||
             nx.pending_next_header == NH_FRAGMENT     ||
             nx.pending_next_header == NH_DEST_OPTIONS;

    if (!cur.walk_done) begin
      if (cur.length_byte_next) begin
        if ((OFFSET_BITS+1)'(cur.byte_offset) ==
            (OFFSET_BITS+1)'(cur.header_start) + (OFFSET_BITS+1)'(1)) begin
          nx.length_byte_next = 1'b0;
          if (next_start >= (OFFSET_BITS+1)'(OFFSET_MAX)) begin
            nx.walk_done = 1'b1;
          end else begin
            nx.header_start = next_start[OFFSET_BITS-1:0];
          end
        end
      end else if (cur.byte_offset == cur.header_start) begin
        if (nx.pending_next_header == NH_ICMPV6) begin
          ext_bytes    = 17'(cur.header_start) - 17'(FIXED_HDR_BYTES);
          query_diff   = {1'b0, nx.payload_length} - ext_bytes;
          nx.walk_done = 1'b1;
          if (!query_diff[16]) begin
            nx.held_length = query_diff[15:0];
            if (nx.address_matches && b == cfg_i.query_type_code) begin
              if (query_diff[15:0] == cfg_i.v1_query_size) begin
                nx.held_verdict = VERDICT_MLDV1;
              end else if (query_diff[15:0] >= cfg_i.v2_min_query_size) begin
                nx.held_verdict = VERDICT_MLDV2;
              end
            end
          end
        end else if (is_ext) begin
          nx.pending_next_header = b;
          nx.length_byte_next    = 1'b1;
        end else begin
          nx.walk_done = 1'b1;
        end
      end
    end

    if (cur.byte_offset != OFFSET_MAX) begin
      nx.byte_offset = cur.byte_offset + OFFSET_BITS'(1);
    end

    if (cfg_i.family_is_ipv6 && nx.walk_done) begin
      res.verdict      = nx.held_verdict;
      res.query_length = nx.held_length;
    end else begin
      res.verdict      = VERDICT_NONE;
      res.query_length = '0;
    end

    st_d = st_q;
    if (fire) begin
      st_d = beat_i.item.last_byte ? START_STATE : nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= START_STATE;
    end else begin
      st_q <= st_d;
    end
  end

  assign result_o.valid = fire && beat_i.item.last_byte;
  assign result_o.item  = res;

  a_hdr_start_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.header_start >= FIXED_HDR_BYTES)
    else $error("header start below fixed header");

  a_hdr_start_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.header_start < OFFSET_MAX)
    else $error("header start reached saturated offset");

  a_verdict_needs_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.held_verdict != VERDICT_NONE |-> st_q.walk_done && st_q.address_matches)
    else $error("verdict held without finished walk or address match");

  a_result_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> out_free_i)
    else $error("result issued while output register busy");

endmodule

// ----- rtl/core/mqc_output_stage.sv -----
// ----------------------------------------------------------------------------
// mqc_output_stage
// Result register holding one verdict beat until the consumer takes it.
// ----------------------------------------------------------------------------
module mqc_output_stage import mqc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  result_beat_t result_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output out_item_t    out_data_o
);

  logic      valid_q, valid_d;
  out_item_t data_q;

  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = result_i.valid || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_i.valid) begin
      data_q <= result_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- rtl/core/mld_query_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// mld_query_classifier_unit
// Classifies IPv6 packets, fed one byte per beat, as MLDv1 or MLDv2 listener
// queries.
// ----------------------------------------------------------------------------
// The block takes one packet byte per clock while it is not held back and
// gives one verdict beat for each byte marked last. A byte passes through
// the input register and the combinational header-walk logic; the verdict
// of a last byte then passes through the result register. With no hold-back
// the sustained rate is one byte per cycle. Input is held back only when a
// last byte reaches the walk logic while the previous verdict still sits
// untaken in the result register. Configuration is written through an
// indexed write port, is registered, and takes effect on the next byte.
// ----------------------------------------------------------------------------
module mld_query_classifier_unit import mqc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_item_t                out_data_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  cfg_t         cfg;
  byte_beat_t   beat;
  result_beat_t result;
  logic         take;
  logic         out_free;

  mqc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mqc_input_stage u_input_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .beat_o     (beat),
    .take_i     (take)
  );

  mqc_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .beat_i     (beat),
    .take_o     (take),
    .out_free_i (out_free),
    .result_o   (result)
  );

  mqc_output_stage u_output_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .result_i    (result),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
